// ===== rtl/core/csfp_pkg.sv =====
// ----------------------------------------------------------------------------
// csfp_pkg - shared types and constants for the frame sync parser
// Frame layout constants, CRC-32 byte update and the queued frame record.
// ----------------------------------------------------------------------------
package csfp_pkg;

    localparam int WIN_LEN     = 16;   // bytes in one frame window
    localparam int CRC_LEN     = 10;   // bytes covered by the CRC (frame bytes 2..11)
    localparam int CRC_DLY_LEN = 4;    // CRC results kept until the carried word arrives
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  MAGIC_A       = 8'h45;
    localparam logic [7:0]  MAGIC_B       = 8'h48;
    localparam logic [7:0]  VERSION_RESET = 8'h01;
    localparam logic [3:0]  WAIT_RELOAD   = 4'hF;
    localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_XOROUT    = 32'hFFFFFFFF;

    typedef struct packed {
        logic [7:0]         src_node;
        logic [15:0]        sequence_number;
        logic signed [31:0] temperature_value;
        logic signed [7:0]  temperature_exponent;
        logic [31:0]        frame_checksum;
    } t_frame;

    // frame record with its valid flag, used for queue push and queue head
    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_entry;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'h0, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/csfp_ifs.sv =====
// ----------------------------------------------------------------------------
// csfp_ifs - channel interfaces of the frame sync parser
// Byte input, frame output and configuration write channels.
// ----------------------------------------------------------------------------
interface csfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface csfp_frame_if;
    logic               valid;
    logic               ready;
    logic [7:0]         src_node;
    logic [15:0]        sequence_number;
    logic signed [31:0] temperature_value;
    logic signed [7:0]  temperature_exponent;
    logic [31:0]        frame_checksum;

    modport source (output valid, output src_node, output sequence_number,
                    output temperature_value, output temperature_exponent,
                    output frame_checksum, input ready);
    modport sink   (input valid, input src_node, input sequence_number,
                    input temperature_value, input temperature_exponent,
                    input frame_checksum, output ready);
endinterface

interface csfp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/csfp_front.sv =====
// ----------------------------------------------------------------------------
// csfp_front - byte intake, window, rolling CRC and frame match
// Takes one byte per transaction and pushes each matched frame to the queue.
// ----------------------------------------------------------------------------
module csfp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    csfp_byte_if.sink       i_byte,
    csfp_cfg_if.sink        i_cfg,
    input  logic            i_q_full,
    output csfp_pkg::t_entry o_push
);
    import csfp_pkg::*;

    logic [7:0]  r_hist [WIN_LEN-1];     // last 15 bytes, oldest first
    logic [31:0] r_crc  [CRC_LEN];       // r_crc[j]: CRC state over the last j+1 bytes
    logic [31:0] r_dly  [CRC_DLY_LEN];   // r_dly[k]: final CRC ending k bytes back
    logic [3:0]  r_wait;
    logic [7:0]  r_version;

    logic [7:0]  n_win  [WIN_LEN];
    logic [31:0] n_crc  [CRC_LEN];
    logic [31:0] carried;
    logic        accept;
    logic        hdr_ok;
    logic        crc_ok;
    logic        match;

    assign i_byte.ready = !i_q_full;
    assign i_cfg.ready  = 1'b1;
    assign accept       = i_byte.valid && i_byte.ready;

    always_comb begin
        for (int i = 0; i < WIN_LEN - 1; i++) begin
            n_win[i] = r_hist[i];
        end
        n_win[WIN_LEN-1] = i_byte.data_byte;

        n_crc[0] = crc_byte(CRC_INIT, i_byte.data_byte);
        for (int j = 1; j < CRC_LEN; j++) begin
            n_crc[j] = crc_byte(r_crc[j-1], i_byte.data_byte);
        end
    end

    assign carried = {n_win[12], n_win[13], n_win[14], n_win[15]};
    assign hdr_ok  = (n_win[0] == MAGIC_A) && (n_win[1] == MAGIC_B) &&
                     (n_win[2] == r_version) && (n_win[3] != 8'h00) &&
                     (n_win[4] == 8'h00);
    // new window byte 11 was the newest byte four transactions ago
    assign crc_ok  = (r_dly[CRC_DLY_LEN-1] == carried);
    assign match   = (r_wait == 4'h0) && hdr_ok && crc_ok;

    assign o_push.valid                      = accept && match;
    assign o_push.frame.src_node             = n_win[3];
    assign o_push.frame.sequence_number      = {n_win[5], n_win[6]};
    assign o_push.frame.temperature_value    = {n_win[7], n_win[8], n_win[9], n_win[10]};
    assign o_push.frame.temperature_exponent = n_win[11];
    assign o_push.frame.frame_checksum       = carried;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait    <= WAIT_RELOAD;
            r_version <= VERSION_RESET;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_version <= i_cfg.data;
            end
            if (accept) begin
                if (r_wait != 4'h0) begin
                    r_wait <= r_wait - 4'h1;
                end else if (match) begin
                    r_wait <= WAIT_RELOAD;
                end
            end
        end
    end

    // datapath, no reset: nothing is checked before a full window of real bytes
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                r_hist[i] <= n_win[i+1];
            end
            for (int j = 0; j < CRC_LEN; j++) begin
                r_crc[j] <= n_crc[j];
            end
            r_dly[0] <= n_crc[CRC_LEN-1] ^ CRC_XOROUT;
            for (int k = 1; k < CRC_DLY_LEN; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

endmodule

// ===== rtl/core/csfp_queue.sv =====
// ----------------------------------------------------------------------------
// csfp_queue - short frame queue between front and back
// Small FIFO of matched frames; full stalls the front.
// ----------------------------------------------------------------------------
module csfp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  csfp_pkg::t_entry i_push,
    input  logic             i_pop,
    output logic             o_full,
    output csfp_pkg::t_entry o_head
);
    import csfp_pkg::*;

    t_frame                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr;
    logic [QUEUE_PTR_W-1:0] r_rd;
    logic [QUEUE_CNT_W-1:0] r_cnt;
    logic                   do_push;
    logic                   do_pop;

    assign o_full       = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.frame = r_mem[r_rd];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.frame;
        end
    end

endmodule

// ===== rtl/core/csfp_back.sv =====
// ----------------------------------------------------------------------------
// csfp_back - result output stage
// Pulls frames from the queue into the output register and presents them.
// ----------------------------------------------------------------------------
module csfp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  csfp_pkg::t_entry i_head,
    output logic             o_pop,
    csfp_frame_if.source     o_frame
);
    import csfp_pkg::*;

    logic   r_valid;
    t_frame r_out;

    // load when the register is empty or being emptied this cycle
    assign o_pop = i_head.valid && (!r_valid || o_frame.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= i_head.frame;
        end
    end

    assign o_frame.valid                = r_valid;
    assign o_frame.src_node             = r_out.src_node;
    assign o_frame.sequence_number      = r_out.sequence_number;
    assign o_frame.temperature_value    = r_out.temperature_value;
    assign o_frame.temperature_exponent = r_out.temperature_exponent;
    assign o_frame.frame_checksum       = r_out.frame_checksum;

endmodule

// ===== rtl/core/crc_checked_frame_sync_parser.sv =====
// ----------------------------------------------------------------------------
// crc_checked_frame_sync_parser - sync-word frame parser with CRC-32 check
// Hunts 16-byte frames in a byte stream and emits the fields of each good one.
// ----------------------------------------------------------------------------
// The parser takes one stream byte per transaction on i_byte, one byte every
// clock when ready, and keeps a sliding 16-byte window. Each window whose
// bytes are not part of an already accepted frame is tested: sync bytes 0x45
// 0x48, version equal to the configured value, nonzero source node, zero
// target node, and a reflected CRC-32 (poly 0xEDB88320, init and final xor
// all ones) over bytes 2..11 equal to the big-endian word in bytes 12..15.
// A good frame produces one transaction on o_frame and the next 15 bytes are
// skipped, so frames never overlap. After reset the first 15 bytes only fill
// the window. The CRC is kept as a row of ten running byte-wise CRC registers,
// one started per byte, so the check costs one byte update per register per
// clock while bytes are accepted; the decision is made on the accepting clock
// edge, which writes a good frame into the queue. From there it moves into the
// output register, which drives o_frame. A two-entry
// queue and the output register absorb back-pressure; i_byte.ready only drops
// when both queue entries are taken. i_cfg carries the expected version
// (reset 1) and is always ready; write it only while the parser is idle.
// ----------------------------------------------------------------------------
module crc_checked_frame_sync_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    csfp_byte_if.sink    i_byte,
    csfp_cfg_if.sink     i_cfg,
    csfp_frame_if.source o_frame
);
    import csfp_pkg::*;

    t_entry push;    // front -> queue
    t_entry head;    // queue -> back
    logic   q_full;
    logic   pop;

    // front: window, CRC row, skip counter, match
    csfp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push)
    );

    // queue: decouples matching from the output handshake
    csfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    // back: output register
    csfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_frame (o_frame)
    );

endmodule

// ===== rtl/core/csfp_checker.sv =====
// ----------------------------------------------------------------------------
// csfp_checker - port-level assertions for the frame sync parser
// Bound to the top level; watches the channel handshakes over time.
// ----------------------------------------------------------------------------
module csfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [95:0] i_out_payload
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("result changed or dropped while stalled");

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    // a fresh result traces back to a byte taken, through the queue and the output register
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without a matching byte transaction");

    // with the output empty the queue cannot be full
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output idle");

endmodule

bind crc_checked_frame_sync_parser csfp_checker u_csfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_byte.valid),
    .i_in_ready    (i_byte.ready),
    .i_out_valid   (o_frame.valid),
    .i_out_ready   (o_frame.ready),
    .i_out_payload ({o_frame.src_node, o_frame.sequence_number,
                     o_frame.temperature_value, o_frame.temperature_exponent,
                     o_frame.frame_checksum})
);
